### hdl/gps_pkg.sv
// shared types and constants for the gaussian path smoother
package gps_pkg;

  localparam int MaxHalfWidthDef   = 63;
  localparam int CoordBitsDef      = 32;
  localparam int WeightFracBitsDef = 15;

  // configuration register indexes
  localparam logic [1:0] RegHalfWidth = 2'd0;
  localparam logic [1:0] RegPosEnable = 2'd1;
  localparam logic [1:0] RegTgtEnable = 2'd2;

  // input op codes
  localparam logic OpWeight = 1'b0;
  localparam logic OpNode   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN,
    ST_DONE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       shift_in;
    logic       clear_acc;
    logic       mac;
    logic       load_out;
    logic       out_last;
    logic [6:0] center;
    logic [6:0] tap_pos;
    logic [5:0] tap_dist;
  } cmd_t;

endpackage

### hdl/gps_ctrl.sv
// sequencer: accepts beats, walks the taps of each result and hands results out
module gps_ctrl #(
  parameter int MaxHalfWidth = gps_pkg::MaxHalfWidthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_op,
  input  logic           in_is_last,
  input  logic [5:0]     half_width,
  input  logic           out_busy,
  output gps_pkg::cmd_t  cmd
);

  localparam int Depth = 2 * MaxHalfWidth + 1;

  gps_pkg::state_t state, state_next;
  logic [6:0] nodes_seen, nodes_seen_next;
  logic [6:0] center, center_next;
  logic signed [7:0] k, k_next;
  logic [1:0] drain, drain_next;
  logic       flushing, flushing_next;
  logic [5:0] hw;
  logic signed [8:0] pos;
  logic [6:0] kabs;

  assign hw = (half_width > 6'(MaxHalfWidth)) ? 6'(MaxHalfWidth) : half_width;

  // tap position with edge clamp
  always_comb begin
    pos  = $signed({2'b00, center}) - 9'(k);
    kabs = k[7] ? 7'(-k) : 7'(k);
    if (pos < 0) pos = '0;
    if (pos > $signed({2'b00, nodes_seen}) - 9'sd1) pos = $signed({2'b00, nodes_seen}) - 9'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gps_pkg::ST_IDLE;
      nodes_seen <= '0;
      flushing   <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_seen <= nodes_seen_next;
      flushing   <= flushing_next;
    end
    center <= center_next;
    k      <= k_next;
    drain  <= drain_next;
  end

  always_comb begin
    state_next      = state;
    nodes_seen_next = nodes_seen;
    flushing_next   = flushing;
    center_next     = center;
    k_next          = k;
    drain_next      = drain;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.center      = center;
    cmd.tap_pos     = 7'(pos);
    cmd.tap_dist    = kabs[5:0];
    cmd.out_last    = flushing && (center == 7'd0);
    unique case (state)
      gps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_op == gps_pkg::OpNode) begin
          cmd.shift_in = 1'b1;
          if (nodes_seen < 7'(Depth)) nodes_seen_next = nodes_seen + 7'd1;
          else nodes_seen_next = nodes_seen;
          k_next = -$signed({2'b00, hw});
          cmd.clear_acc = 1'b1;
          if (in_is_last) begin
            flushing_next = 1'b1;
            center_next = (nodes_seen_next - 7'd1 < 7'(hw)) ? nodes_seen_next - 7'd1 : 7'(hw);
            state_next = gps_pkg::ST_TAP;
          end else if (nodes_seen_next > 7'(hw)) begin
            flushing_next = 1'b0;
            center_next = 7'(hw);
            state_next = gps_pkg::ST_TAP;
          end
        end
      end
      gps_pkg::ST_TAP: begin
        cmd.mac = 1'b1;
        if (k == $signed({2'b00, hw})) begin
          drain_next = 2'd2;
          state_next = gps_pkg::ST_DRAIN;
        end else k_next = k + 8'sd1;
      end
      gps_pkg::ST_DRAIN: begin
        // wait for the multiplier pipe to settle into the sums
        if (drain == 2'd0) state_next = gps_pkg::ST_DONE;
        else drain_next = drain - 2'd1;
      end
      gps_pkg::ST_DONE: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          state_next = gps_pkg::ST_OUT;
        end
      end
      gps_pkg::ST_OUT: begin
        k_next = -$signed({2'b00, hw});
        cmd.clear_acc = 1'b1;
        if (flushing && center != 7'd0) begin
          center_next = center - 7'd1;
          state_next = gps_pkg::ST_TAP;
        end else begin
          if (flushing) nodes_seen_next = '0;
          flushing_next = 1'b0;
          state_next = gps_pkg::ST_IDLE;
        end
      end
      default: state_next = gps_pkg::ST_IDLE;
    endcase
  end

  // a result is loaded only once the tap walk has finished
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> $past(state) == gps_pkg::ST_DRAIN || $past(state) == gps_pkg::ST_DONE)
    else $error("result loaded before tap walk ended");
  // no node taken while a result is being computed
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == gps_pkg::ST_IDLE)
    else $error("input taken while busy");
  // held count never passes the window depth
  assert property (@(posedge clk) disable iff (rst)
    nodes_seen <= 7'(Depth))
    else $error("node count overflow");

endmodule

### hdl/gps_datapath.sv
// window memory, weight memory, shared multiply-accumulate and output register
module gps_datapath #(
  parameter int MaxHalfWidth   = gps_pkg::MaxHalfWidthDef,
  parameter int CoordBits      = gps_pkg::CoordBitsDef,
  parameter int WeightFracBits = gps_pkg::WeightFracBitsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  gps_pkg::cmd_t cmd,
  input  logic          wt_we,
  input  logic [5:0]    wt_addr,
  input  logic [15:0]   wt_data,
  input  logic [223:0]  node_in,
  input  logic          pos_en,
  input  logic          tgt_en,
  output logic          out_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [223:0]  out_data,
  output logic          out_last
);

  localparam int Depth  = 2 * MaxHalfWidth + 1;
  localparam int AddrW  = $clog2(Depth);
  localparam int AccW   = CoordBits + 17 + 7;

  logic [15:0] wt_mem [64];
  logic [223:0] win_mem [Depth];
  logic [AddrW-1:0] head;
  logic [223:0] tap_q, ctr_q;
  logic [15:0] w_q;
  logic        v1, v2;
  logic signed [CoordBits+16:0] prod [6];
  logic signed [AccW-1:0] acc [6];
  logic [AddrW-1:0] tap_addr, ctr_addr;

  // newest node sits at head; distance i back is head+i modulo depth
  always_comb begin
    logic [AddrW:0] s1, s2;
    s1 = {1'b0, head} + (AddrW+1)'(cmd.tap_pos);
    s2 = {1'b0, head} + (AddrW+1)'(cmd.center);
    tap_addr = (s1 >= (AddrW+1)'(Depth)) ? AddrW'(s1 - (AddrW+1)'(Depth)) : s1[AddrW-1:0];
    ctr_addr = (s2 >= (AddrW+1)'(Depth)) ? AddrW'(s2 - (AddrW+1)'(Depth)) : s2[AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_addr] <= wt_data;
    w_q <= wt_mem[cmd.tap_dist];
  end

  always_ff @(posedge clk) begin
    if (rst) head <= '0;
    else if (cmd.shift_in) head <= (head == '0) ? AddrW'(Depth - 1) : head - AddrW'(1);
    if (cmd.shift_in)
      win_mem[(head == '0) ? AddrW'(Depth - 1) : head - AddrW'(1)] <= node_in;
    tap_q <= win_mem[tap_addr];
    ctr_q <= win_mem[ctr_addr];
  end

  // pipe: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac;
      v2 <= v1;
    end
    for (int j = 0; j < 6; j++) begin
      prod[j] <= $signed(tap_q[32*j +: CoordBits]) * $signed({1'b0, w_q});
      if (cmd.clear_acc) acc[j] <= '0;
      else if (v2) acc[j] <= acc[j] + AccW'(prod[j]);
    end
  end

  // output register with round and saturate, or the centre node as it was where smoothing is off
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.load_out) begin
      for (int j = 0; j < 6; j++) begin
        logic signed [AccW-1:0] r, q;
        logic signed [CoordBits-1:0] c;
        r = acc[j] + AccW'(1 << (WeightFracBits - 1));
        q = r >>> WeightFracBits;
        if (q > AccW'((64'sd1 <<< (CoordBits-1)) - 1)) c = {1'b0, {(CoordBits-1){1'b1}}};
        else if (q < -AccW'(64'sd1 <<< (CoordBits-1))) c = {1'b1, {(CoordBits-1){1'b0}}};
        else c = q[CoordBits-1:0];
        if (!((j < 3) ? pos_en : tgt_en)) c = ctr_q[32*j +: CoordBits];
        out_data[32*j +: 32] <= 32'(c);
      end
      out_data[223:192] <= ctr_q[223:192];
      out_last <= cmd.out_last;
    end
  end

  assign out_busy = out_valid && !out_ready;

  // accumulation only while the pipe carries taps
  assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("tap pipe out of order");

endmodule

### hdl/gaussian_path_smoother.sv
// top level: stream and register ports around controller and datapath
// a node that emits walks its taps through the shared multiply-accumulate, lets the pipe drain, waits
// for the output register to be free and loads it; the last node does this per flushed result
// the shared multiply-accumulate walks one tap a cycle; no beat is taken until the result is loaded
// weight beats and nodes that emit nothing are taken in the idle state, which the block does not leave
// rst is synchronous: window empty, half_width 1, both enables on; weights undefined until written
module gaussian_path_smoother #(
  parameter int MaxHalfWidth   = gps_pkg::MaxHalfWidthDef,
  parameter int CoordBits      = gps_pkg::CoordBitsDef,
  parameter int WeightFracBits = gps_pkg::WeightFracBitsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // weight_index[5:0], weight_value[21:6], in_pos_x..in_tgt_z, in_delta_t, pad
  input  logic [255:0] s_tdata,
  // op
  input  logic         s_tuser,
  // in_last
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_tgt_x, out_tgt_y, out_tgt_z, out_delta_t
  output logic [223:0] m_tdata,
  // out_last
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [5:0] half_width;
  logic pos_en, tgt_en, out_busy, in_ready;
  gps_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign s_tready = in_ready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= 6'd1;
      pos_en <= 1'b1;
      tgt_en <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[3:2] == gps_pkg::RegHalfWidth) half_width <= pwdata[5:0];
      if (paddr[3:2] == gps_pkg::RegPosEnable) pos_en <= pwdata[0];
      if (paddr[3:2] == gps_pkg::RegTgtEnable) tgt_en <= pwdata[0];
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gps_pkg::RegHalfWidth: prdata = {26'd0, half_width};
      gps_pkg::RegPosEnable: prdata = {31'd0, pos_en};
      gps_pkg::RegTgtEnable: prdata = {31'd0, tgt_en};
      default:               prdata = '0;
    endcase
  end

  gps_ctrl #(.MaxHalfWidth(MaxHalfWidth)) u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready, .in_op(s_tuser), .in_is_last(s_tlast),
    .half_width, .out_busy, .cmd
  );

  gps_datapath #(.MaxHalfWidth(MaxHalfWidth), .CoordBits(CoordBits),
                 .WeightFracBits(WeightFracBits)) u_dp (
    .clk, .rst, .cmd,
    .wt_we(s_tvalid && in_ready && s_tuser == gps_pkg::OpWeight),
    .wt_addr(s_tdata[5:0]), .wt_data(s_tdata[21:6]), .node_in(s_tdata[245:22]),
    .pos_en, .tgt_en, .out_busy,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata), .out_last(m_tlast)
  );

endmodule

### tb/testbench.sv
// self-checking stream testbench for the gaussian path smoother
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WinDepth = 2 * gps_pkg::MaxHalfWidthDef + 1;

  typedef struct {
    logic        op;
    logic [5:0]  widx;
    logic [15:0] wval;
    logic [31:0] coord [6];
    logic [31:0] dt;
    logic        last;
  } beat_t;

  typedef struct {
    logic [223:0] data;
    logic         last;
  } smoothed_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [223:0] m_tdata;
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  gaussian_path_smoother dut (.*);

  always #1 clk = ~clk;

  // pending input beats and predicted smoothed nodes
  beat_t     pending_q [$];
  smoothed_t smoothed_q [$];

  // predictor state
  logic [15:0] tap_weight [64];
  longint      win_coord [WinDepth][6];
  logic [31:0] win_dt [WinDepth];
  int          held_nodes = 0;
  int          cur_hw = 1;
  bit          pos_en = 1'b1;
  bit          tgt_en = 1'b1;

  int  accept_cnt = 0;
  int  seen_cnt = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  did_hold = 1'b0;
  bit  quiet = 1'b0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  nodes_sent = 0;
  int  weights_sent = 0;

  function automatic logic [255:0] pack_beat(beat_t b);
    logic [255:0] d;
    d = '0;
    d[5:0]  = b.widx;
    d[21:6] = b.wval;
    for (int j = 0; j < 6; j++) d[22 + 32*j +: 32] = b.coord[j];
    d[214 +: 32] = b.dt;
    return d;
  endfunction

  function automatic longint round_saturate(longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // one smoothed node centered at window slot ctr
  function automatic smoothed_t smooth_node(int ctr, int hw, bit last);
    smoothed_t r;
    longint    acc [6];
    longint    v;
    int        p;
    int        d;
    for (int j = 0; j < 6; j++) acc[j] = 0;
    for (int k = -hw; k <= hw; k++) begin
      p = ctr - k;
      d = (k < 0) ? -k : k;
      if (p < 0) p = 0;
      if (p > held_nodes - 1) p = held_nodes - 1;
      for (int j = 0; j < 6; j++) acc[j] += win_coord[p][j] * longint'(tap_weight[d]);
    end
    for (int j = 0; j < 6; j++) begin
      v = ((j < 3) ? pos_en : tgt_en) ? round_saturate(acc[j]) : win_coord[ctr][j];
      r.data[32*j +: 32] = v[31:0];
    end
    r.data[192 +: 32] = win_dt[ctr];
    r.last = last;
    return r;
  endfunction

  task automatic predict_beat(beat_t b);
    int q;
    if (b.op == gps_pkg::OpWeight) begin
      tap_weight[b.widx] = b.wval;
      return;
    end
    for (int i = WinDepth - 1; i > 0; i--) begin
      win_coord[i] = win_coord[i-1];
      win_dt[i] = win_dt[i-1];
    end
    for (int j = 0; j < 6; j++) win_coord[0][j] = longint'($signed(b.coord[j]));
    win_dt[0] = b.dt;
    if (held_nodes < WinDepth) held_nodes++;
    if (!b.last) begin
      if (held_nodes > cur_hw)
        smoothed_q.insert(smoothed_q.size(), smooth_node(cur_hw, cur_hw, 1'b0));
    end else begin
      q = (held_nodes - 1 < cur_hw) ? held_nodes - 1 : cur_hw;
      for (; q >= 0; q--) smoothed_q.insert(smoothed_q.size(), smooth_node(q, cur_hw, q == 0));
      held_nodes = 0;
    end
  endtask

  // input beat accepted: predict and retire it
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_beat(pending_q.pop_front());
      accept_cnt++;
    end
  end

  // input driver with random gaps
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && accept_cnt == seen_cnt)) begin
      seen_cnt = accept_cnt;
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(1, 14);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= pack_beat(pending_q[0]);
        s_tuser  <= pending_q[0].op;
        s_tlast  <= pending_q[0].last;
      end
    end
  end

  // output ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!did_hold && results_seen >= 30) begin
      did_hold = 1'b1;
      hold_left = 3000;
      m_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // output monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin
    smoothed_t exp_node;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (smoothed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat: data=%h last=%b", m_tdata, m_tlast);
      end else begin
        exp_node = smoothed_q.pop_front();
        if (exp_node.data !== m_tdata || exp_node.last !== m_tlast) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d:", results_seen);
            for (int j = 0; j < 7; j++)
              $display("  field %0d expected %h actual %h", j,
                       exp_node.data[32*j +: 32], m_tdata[32*j +: 32]);
            $display("  last expected %b actual %b", exp_node.last, m_tlast);
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    unique case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 8192)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_weight(int idx, int val);
    beat_t b;
    b.op = gps_pkg::OpWeight;
    b.widx = idx[5:0];
    b.wval = val[15:0];
    for (int j = 0; j < 6; j++) b.coord[j] = $urandom;
    b.dt = $urandom;
    b.last = 1'($urandom_range(0, 1));
    pending_q.insert(pending_q.size(), b);
    weights_sent++;
  endtask

  task automatic add_node(logic [31:0] c, bit last);
    beat_t b;
    b.op = gps_pkg::OpNode;
    b.widx = 6'($urandom);
    b.wval = 16'($urandom);
    for (int j = 0; j < 6; j++) b.coord[j] = (c === 'x) ? pick_coord() : c;
    b.dt = $urandom;
    b.last = last;
    pending_q.insert(pending_q.size(), b);
    nodes_sent++;
  endtask

  // a path of random nodes, weight writes sprinkled in as noise
  task automatic add_path(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_weight($urandom_range(0, 63), $urandom_range(0, 32768));
      add_node('x, i == len - 1);
    end
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == gps_pkg::RegHalfWidth) cur_hw = val[5:0];
    else if (idx == gps_pkg::RegPosEnable) pos_en = val[0];
    else if (idx == gps_pkg::RegTgtEnable) tgt_en = val[0];
  endtask

  task automatic drain_all();
    while (pending_q.size() != 0 || smoothed_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (2 * gps_pkg::MaxHalfWidthDef + 10) @(posedge clk);
  endtask

  task automatic run_phase(int hw, bit pe, bit te, int node_budget, int max_len);
    int start;
    drain_all();
    apb_write(gps_pkg::RegHalfWidth, hw);
    apb_write(gps_pkg::RegPosEnable, {31'd0, pe});
    apb_write(gps_pkg::RegTgtEnable, {31'd0, te});
    start = nodes_sent;
    while (nodes_sent - start < node_budget) add_path($urandom_range(1, max_len));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full weight table so no unwritten tap is ever read
    for (int i = 0; i < 64; i++) add_weight(i, $urandom_range(0, 16384));
    add_weight(0, 32768);
    add_weight(1, 32768);

    // saturation at both rails, short paths, lone node
    add_node(32'h7fff_ffff, 1'b0);
    add_node(32'h7fff_ffff, 1'b0);
    add_node(32'h7fff_ffff, 1'b1);
    add_node(32'h8000_0000, 1'b0);
    add_node(32'h8000_0000, 1'b1);
    add_node(32'h0000_0000, 1'b1);
    add_weight(1, 0);
    add_node('x, 1'b0);
    add_node('x, 1'b0);
    add_node('x, 1'b0);
    add_node(32'hffff_ffff, 1'b1);

    run_phase(1, 1'b1, 1'b1, 40, 8);
    run_phase(0, 1'b1, 1'b1, 30, 6);
    run_phase(2, 1'b0, 1'b0, 30, 8);
    run_phase(63, 1'b1, 1'b0, 5, 5);
    add_path(140);
    run_phase(3, 1'b0, 1'b1, 20, 8);
    run_phase(7, 1'b1, 1'b1, 50, 20);
    drain_all();
    quiet = 1'b1;
    run_phase(4, 1'b1, 1'b1, 30, 10);
    drain_all();

    $display("nodes sent %0d, weight writes %0d, smoothed nodes checked %0d",
             nodes_sent, weights_sent, results_seen);
    $display("half widths 0 to 63, both enables toggled, long paths and output hold-off");
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("** gaussian_path_smoother: PASSED **");
    end else begin
      $display("mismatches %0d, predictions left over %0d", mismatches, smoothed_q.size());
      $display("** gaussian_path_smoother: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("** gaussian_path_smoother: FAILED **");
    $finish;
  end

endmodule

### sim.f
hdl/gps_pkg.sv
hdl/gps_ctrl.sv
hdl/gps_datapath.sv
hdl/gaussian_path_smoother.sv
tb/testbench.sv
